// File: rtl/core/msc_pkg.sv
// Package for the merge sort block: sequencer state and range-frame phase types.
// No dependencies; imported by merge_sort_with_comparison_count.
`default_nettype none

package msc_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_COPY,
    ST_CWAIT,
    ST_MREAD,
    ST_MCMP,
    ST_ORD,
    ST_OLOAD,
    ST_OWAIT
  } state_t;

  // progress of one range on the recursion stack
  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_MERGE
  } phase_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// File: rtl/core/merge_sort_with_comparison_count.sv
// Merge sort with comparison count: collects signed words, sorts a set
// top-down and streams it back out. Depends on msc_pkg.
//
// Input words are taken one per cycle while the block is idle and written to
// the element memory; words beyond SIZE are dropped and flagged. A word with
// last set closes the set and starts a stable ascending top-down merge sort
// (split at floor((lo+hi)/2), ties take the left element). The recursion runs
// on a small stack of ranges in registers; each merge first copies its range
// to a scratch memory, then places its elements one at a time, reading each
// pair in ST_MREAD and writing the chosen one through the single write port
// of the element memory in ST_MCMP, before the range leaves the stack.
// Results then leave one word at a time, each held on out_valid until
// out_stall is low; each carries the merge comparison count (saturating at
// 1023) and the drop flag. in_stall stays high from the closing word until
// the last result is taken.
`default_nettype none

module merge_sort_with_comparison_count import msc_pkg::*; #(
  parameter int unsigned SIZE = 64
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  signed [VALUE_W-1:0] value,
  input  wire                       last,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic                      last_of_run,
  output logic        [COUNT_W-1:0] comparison_count,
  output logic                      dropped
);

  localparam int unsigned IW  = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int unsigned CW  = $clog2(SIZE + 1);
  localparam int unsigned SD  = $clog2(SIZE) + 1;
  localparam int unsigned SPW = $clog2(SD + 1);
  localparam int unsigned TIW = (SD > 1) ? $clog2(SD) : 1;

  // memories
  logic signed [VALUE_W-1:0] elem_mem [SIZE];
  logic signed [VALUE_W-1:0] scr_mem  [SIZE];

  // recursion stack
  logic [CW-1:0] stk_lo [SD];
  logic [CW-1:0] stk_hi [SD];
  phase_t        stk_ph [SD];
  logic [SPW-1:0] sp;

  state_t state, state_next;

  logic [CW-1:0]      fill_count;
  logic               overflow_seen;
  logic [COUNT_W-1:0] compare_total;

  // merge pointers
  logic [CW-1:0] cidx, mi, mj, mk, mmid, mhi;
  logic [CW-1:0] oidx;

  // scratch copy write stage
  logic          cp_wv;
  logic [CW-1:0] cp_wa;

  logic signed [VALUE_W-1:0] elem_rdata, sa, sb;

  // combinational helpers
  logic [TIW-1:0] top_idx;
  logic [CW-1:0]  top_lo, top_hi, top_mid;
  phase_t         top_ph;
  logic [CW:0]    top_sum;
  logic           in_acc, out_acc, has_room;
  logic [CW-1:0]  n_new;
  logic           take_left, right_live, merge_done;
  logic [CW-1:0]  mi_next;
  logic [CW-1:0]  elem_raddr;
  logic           elem_we;
  logic [CW-1:0]  elem_waddr;
  logic signed [VALUE_W-1:0] elem_wdata;

  // top of stack and split point
  always_comb begin
    top_idx = TIW'(sp - SPW'(1));
    top_lo  = stk_lo[top_idx];
    top_hi  = stk_hi[top_idx];
    top_ph  = stk_ph[top_idx];
    top_sum = {1'b0, top_lo} + {1'b0, top_hi};
    top_mid = top_sum[CW:1];
  end

  // handshake and load
  always_comb begin
    in_acc   = in_valid && !in_stall;
    out_acc  = out_valid && !out_stall;
    has_room = fill_count < CW'(SIZE);
    n_new    = has_room ? fill_count + CW'(1) : fill_count;
  end

  // merge decision
  always_comb begin
    right_live = mj <= mhi;
    take_left  = !right_live || (sa <= sb);
    mi_next    = take_left ? mi + CW'(1) : mi;
    merge_done = mi_next > mmid;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && last) state_next = (n_new > CW'(1)) ? ST_SPLIT : ST_ORD;
      end
      ST_SPLIT: begin
        if (top_ph == PH_MERGE) state_next = ST_COPY;
      end
      ST_COPY: begin
        if (cidx == mhi) state_next = ST_CWAIT;
      end
      ST_CWAIT: state_next = ST_MREAD;
      ST_MREAD: state_next = ST_MCMP;
      ST_MCMP: begin
        if (merge_done) state_next = (sp == SPW'(1)) ? ST_ORD : ST_SPLIT;
        else state_next = ST_MREAD;
      end
      ST_ORD:   state_next = ST_OLOAD;
      ST_OLOAD: state_next = ST_OWAIT;
      ST_OWAIT: begin
        if (out_acc) state_next = last_of_run ? ST_IDLE : ST_ORD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_stall   = (state != ST_IDLE);
    elem_raddr = (state == ST_COPY) ? cidx : oidx;
    elem_we    = 1'b0;
    elem_waddr = fill_count;
    elem_wdata = value;
    unique case (state)
      ST_IDLE: begin
        elem_we = in_acc && has_room;
      end
      ST_MCMP: begin
        elem_we    = 1'b1;
        elem_waddr = mk;
        elem_wdata = take_left ? sa : sb;
      end
      default: elem_we = 1'b0;
    endcase
  end

  // element memory
  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr[IW-1:0]] <= elem_wdata;
    elem_rdata <= elem_mem[elem_raddr[IW-1:0]];
  end

  // scratch memory, two read ports
  always_ff @(posedge clk) begin
    if (cp_wv) scr_mem[cp_wa[IW-1:0]] <= elem_rdata;
    sa <= scr_mem[mi[IW-1:0]];
    sb <= scr_mem[mj[IW-1:0]];
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sp            <= '0;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      compare_total <= '0;
      out_valid     <= 1'b0;
      cp_wv         <= 1'b0;
    end else begin
      state <= state_next;
      cp_wv <= (state == ST_COPY);
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            fill_count <= n_new;
            if (!has_room) overflow_seen <= 1'b1;
            if (last) begin
              compare_total <= '0;
              oidx          <= '0;
              if (n_new > CW'(1)) begin
                stk_lo[0] <= '0;
                stk_hi[0] <= n_new - CW'(1);
                stk_ph[0] <= PH_LEFT;
                sp        <= SPW'(1);
              end
            end
          end
        end
        ST_SPLIT: begin
          unique case (top_ph)
            PH_LEFT: begin
              stk_ph[top_idx] <= PH_RIGHT;
              if (top_lo < top_mid) begin
                stk_lo[TIW'(sp)] <= top_lo;
                stk_hi[TIW'(sp)] <= top_mid;
                stk_ph[TIW'(sp)] <= PH_LEFT;
                sp <= sp + SPW'(1);
              end
            end
            PH_RIGHT: begin
              stk_ph[top_idx] <= PH_MERGE;
              if (top_mid + CW'(1) < top_hi) begin
                stk_lo[TIW'(sp)] <= top_mid + CW'(1);
                stk_hi[TIW'(sp)] <= top_hi;
                stk_ph[TIW'(sp)] <= PH_LEFT;
                sp <= sp + SPW'(1);
              end
            end
            PH_MERGE: begin
              cidx <= top_lo;
              mi   <= top_lo;
              mk   <= top_lo;
              mj   <= top_mid + CW'(1);
              mmid <= top_mid;
              mhi  <= top_hi;
            end
            default: sp <= sp;
          endcase
        end
        ST_COPY: begin
          cidx <= cidx + CW'(1);
        end
        ST_MCMP: begin
          mi <= mi_next;
          mk <= mk + CW'(1);
          if (!take_left) mj <= mj + CW'(1);
          if (right_live && compare_total != COUNT_MAX)
            compare_total <= compare_total + COUNT_W'(1);
          if (merge_done) sp <= sp - SPW'(1);
        end
        ST_OLOAD: begin
          out_valid <= 1'b1;
        end
        ST_OWAIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            oidx      <= oidx + CW'(1);
            if (last_of_run) begin
              fill_count    <= '0;
              overflow_seen <= 1'b0;
              compare_total <= '0;
            end
          end
        end
        default: sp <= sp;
      endcase
    end
  end

  // copy pipeline address and result word
  always_ff @(posedge clk) begin
    cp_wa <= cidx;
    if (state == ST_OLOAD) begin
      sorted_value     <= elem_rdata;
      last_of_run      <= (oidx + CW'(1) == fill_count);
      comparison_count <= compare_total;
      dropped          <= overflow_seen;
    end
  end

  // checks
  a_out_stack_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sp == '0))
    else $error("result word shown while ranges remain on the stack");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(SIZE))
    else $error("fill count beyond capacity");

  a_merge_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MCMP) |-> (mi <= mmid && mk <= mhi))
    else $error("merge pointer out of range");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_of_run) |=> (fill_count == '0 && !out_valid))
    else $error("set not cleared after final result word");

endmodule

`default_nettype wire
